// ----- rtl/cee_pkg.sv -----
// ----------------------------------------------------------------------------
// Character escape encoder package
// Shared types, character codes and the classification and digit functions
// used by the front end and the back end of the escape encoder.
// ----------------------------------------------------------------------------
package cee_pkg;

  // Escape form selected by the configuration register.
  typedef enum logic [2:0] {
    MODE_HEX   = 3'd0,
    MODE_OCT   = 3'd1,
    MODE_CARET = 3'd2,
    MODE_U4    = 3'd3,
    MODE_U8    = 3'd4
  } mode_t;

  // Default depth of the job queue between the front and back ends.
  localparam int JOB_DEPTH_DEF = 4;

  // Width of the digit count of one job (up to eight digits).
  localparam int NDIG_W = 4;

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BSL   = 8'h5C;  // backslash
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_QM    = 8'h3F;  // question mark
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_LX    = 8'h78;  // 'x'
  localparam logic [7:0] CH_LU    = 8'h75;  // 'u'
  localparam logic [7:0] CH_UU    = 8'h55;  // 'U'
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CARET_OFS = 8'h40;

  // One input beat.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] out_char;
    logic       run_end;
  } out_item_t;

  // A classified byte: up to two prefix characters, then ndig digits of val
  // from the most significant one down, in octal or hex.
  typedef struct packed {
    logic [1:0]        pre_cnt;
    logic [7:0]        pre0;
    logic [7:0]        pre1;
    logic [NDIG_W-1:0] ndig;
    logic              oct;
    logic [7:0]        val;
    logic              run_end;
  } job_t;

  // Jobs handed from the front end to the queue in one cycle.
  typedef struct packed {
    logic [1:0] cnt;
    job_t       j0;
    job_t       j1;
  } job_push_t;

  // Letter of a backslash escape, or NUL when the byte has none.
  function automatic logic [7:0] letter_for(logic [7:0] prev, logic [7:0] c);
    logic [7:0] e;
    case (c)
      CH_QUOTE: e = CH_QUOTE;
      CH_DQUOT: e = CH_DQUOT;
      8'd7:     e = 8'h61;  // a
      8'd8:     e = 8'h62;  // b
      8'd12:    e = 8'h66;  // f
      8'd10:    e = 8'h6E;  // n
      8'd13:    e = 8'h72;  // r
      8'd9:     e = 8'h74;  // t
      8'd11:    e = 8'h76;  // v
      CH_QM:    e = (prev == CH_QM) ? CH_QM : CH_NUL;
      default:  e = CH_NUL;
    endcase
    return e;
  endfunction

  // Lowercase hex character of a digit value.
  function automatic logic [7:0] digit_char(logic [3:0] d);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = 8'h30 + {4'd0, d};
    end else begin
      ch = 8'h57 + {4'd0, d};
    end
    return ch;
  endfunction

  // Turn one byte, its predecessor and its lookahead into a job.
  function automatic job_t classify(mode_t mode, logic [7:0] prev, logic [7:0] c,
                                    logic [7:0] nxt, logic run_end);
    job_t       j;
    logic [7:0] e;
    logic       nd_dec;
    logic       nd_hex;
    j         = '0;
    j.val     = c;
    j.run_end = run_end;
    e         = letter_for(prev, c);
    nd_dec    = nxt inside {[8'h30:8'h39]};
    nd_hex    = nd_dec || (nxt inside {[8'h61:8'h66], [8'h41:8'h46]});
    if ((mode != MODE_CARET) && (e != CH_NUL)) begin
      j.pre_cnt = 2'd2;
      j.pre0    = CH_BSL;
      j.pre1    = e;
    end else if (c inside {[8'd32:8'd126]}) begin
      j.pre_cnt = 2'd1;
      j.pre0    = c;
    end else if (mode == MODE_CARET) begin
      if (c < 8'd32) begin
        j.pre_cnt = 2'd2;
        j.pre0    = CH_CARET;
        j.pre1    = c + CARET_OFS;
      end else if (c == CH_DEL) begin
        j.pre_cnt = 2'd2;
        j.pre0    = CH_CARET;
        j.pre1    = CH_QM;
      end else begin
        j.pre_cnt = 2'd1;
        j.pre0    = c;
      end
    end else if (mode == MODE_OCT) begin
      j.pre_cnt = 2'd1;
      j.pre0    = CH_BSL;
      j.oct     = 1'b1;
      if (nd_dec || c >= 8'd64) begin
        j.ndig = NDIG_W'(3);
      end else if (c >= 8'd8) begin
        j.ndig = NDIG_W'(2);
      end else begin
        j.ndig = NDIG_W'(1);
      end
    end else begin
      j.pre_cnt = 2'd2;
      j.pre0    = CH_BSL;
      case (mode)
        MODE_U4: j.pre1 = CH_LU;
        MODE_U8: j.pre1 = CH_UU;
        default: j.pre1 = CH_LX;
      endcase
      if (nd_hex) begin
        case (mode)
          MODE_U4: j.ndig = NDIG_W'(4);
          MODE_U8: j.ndig = NDIG_W'(8);
          default: j.ndig = NDIG_W'(2);
        endcase
      end else if (c >= 8'd16) begin
        j.ndig = NDIG_W'(2);
      end else begin
        j.ndig = NDIG_W'(1);
      end
    end
    return j;
  endfunction

endpackage

// ----- rtl/cee_front.sv -----
// ----------------------------------------------------------------------------
// Escape encoder front end
// Holds the configuration register and the pending byte, accepts input beats
// and classifies up to two bytes per beat into jobs for the back end.
// ----------------------------------------------------------------------------
module cee_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  cee_pkg::in_item_t   in_data,
  input  logic                q_full,
  output logic                in_full,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_data,
  output logic                cfg_ready,
  output cee_pkg::job_push_t  push
);
  import cee_pkg::*;

  mode_t      mode_r, mode_nxt;
  logic [7:0] pend_r, pend_nxt;
  logic       pend_valid_r, pend_valid_nxt;
  logic [7:0] before_r, before_nxt;
  logic       accept;
  logic [7:0] prev_b;
  job_t       job_a;
  job_t       job_b;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign accept    = in_push && !q_full;

  // Configuration write; codes past the last form fall back to hex.
  always_comb begin
    mode_nxt = mode_r;
    if (cfg_valid) begin
      if (cfg_data <= 3'(MODE_U8)) begin
        mode_nxt = mode_t'(cfg_data);
      end else begin
        mode_nxt = MODE_HEX;
      end
    end
  end

  // The pending byte is encoded with the new byte as lookahead; on the last
  // beat the new byte follows with a NUL lookahead.
  assign prev_b = pend_valid_r ? pend_r : before_r;
  assign job_a  = classify(mode_r, before_r, pend_r, in_data.in_byte, !in_data.in_last);
  assign job_b  = classify(mode_r, prev_b, in_data.in_byte, CH_NUL, 1'b1);

  // Jobs pushed into the queue this cycle.
  always_comb begin
    push.cnt = 2'd0;
    push.j0  = pend_valid_r ? job_a : job_b;
    push.j1  = job_b;
    if (accept) begin
      push.cnt = {1'b0, pend_valid_r} + {1'b0, in_data.in_last};
    end
  end

  // Pending byte and its predecessor.
  always_comb begin
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    before_nxt     = before_r;
    if (accept) begin
      if (in_data.in_last) begin
        pend_nxt       = CH_NUL;
        pend_valid_nxt = 1'b0;
        before_nxt     = CH_NUL;
      end else begin
        if (pend_valid_r) begin
          before_nxt = pend_r;
        end
        pend_nxt       = in_data.in_byte;
        pend_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_HEX;
      pend_r       <= CH_NUL;
      pend_valid_r <= 1'b0;
      before_r     <= CH_NUL;
    end else begin
      mode_r       <= mode_nxt;
      pend_r       <= pend_nxt;
      pend_valid_r <= pend_valid_nxt;
      before_r     <= before_nxt;
    end
  end

endmodule

// ----- rtl/cee_job_queue.sv -----
// ----------------------------------------------------------------------------
// Escape encoder job queue
// Small queue between front and back end; takes up to two jobs per cycle and
// hands out one. Full is raised while fewer than two entries are free.
// ----------------------------------------------------------------------------
module cee_job_queue #(
  parameter int DEPTH = cee_pkg::JOB_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cee_pkg::job_push_t  push,
  input  logic                pop,
  output cee_pkg::job_t       head,
  output logic                empty,
  output logic                full
);
  import cee_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] wr_ptr_p1;
  logic [PTR_W-1:0] wr_ptr_p2;

  function automatic logic [PTR_W-1:0] inc(logic [PTR_W-1:0] p);
    return (p == LAST_IDX) ? '0 : p + PTR_W'(1);
  endfunction

  assign wr_ptr_p1 = inc(wr_ptr_r);
  assign wr_ptr_p2 = inc(wr_ptr_p1);
  assign head      = mem[rd_ptr_r];
  assign empty     = (cnt_r == '0);
  assign full      = (cnt_r > CNT_W'(DEPTH - 2));

  // Pointer and fill count update.
  always_comb begin
    rd_ptr_nxt = pop ? inc(rd_ptr_r) : rd_ptr_r;
    case (push.cnt)
      2'd1:    wr_ptr_nxt = wr_ptr_p1;
      2'd2:    wr_ptr_nxt = wr_ptr_p2;
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    cnt_nxt = cnt_r + CNT_W'(push.cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.j0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_p1] <= push.j1;
    end
  end

endmodule

// ----- rtl/cee_back.sv -----
// ----------------------------------------------------------------------------
// Escape encoder back end
// Steps through the current job one character per cycle while the result
// queue has room, prefix characters first and then the digits, into a
// two-entry result queue.
module cee_back (
  input  logic                clk,
  input  logic                rst_n,
  input  cee_pkg::job_t       head,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output cee_pkg::out_item_t  out_data
);
  import cee_pkg::*;

  job_t        cur_r, cur_nxt;
  logic        cur_valid_r, cur_valid_nxt;
  out_item_t   oq_r [2];
  logic        oq_wr_r;
  logic        oq_rd_r;
  logic [1:0]  oq_cnt_r;
  logic        emit;
  logic        cur_last;
  logic        finish;
  logic        deq;
  logic [2:0]  dig_idx;
  logic [3:0]  dig_val;
  out_item_t   emit_item;

  // Emit while the result queue has room.
  assign emit     = cur_valid_r && (oq_cnt_r != 2'd2);
  assign cur_last = ((cur_r.pre_cnt == 2'd1) && (cur_r.ndig == '0)) ||
                    ((cur_r.pre_cnt == 2'd0) && (cur_r.ndig == NDIG_W'(1)));
  assign finish   = emit && cur_last;
  assign q_pop    = !q_empty && (!cur_valid_r || finish);

  // Digit of the value at the current position.
  assign dig_idx = 3'(cur_r.ndig - NDIG_W'(1));
  always_comb begin
    if (cur_r.oct) begin
      case (dig_idx)
        3'd0:    dig_val = {1'b0, cur_r.val[2:0]};
        3'd1:    dig_val = {1'b0, cur_r.val[5:3]};
        3'd2:    dig_val = {2'b00, cur_r.val[7:6]};
        default: dig_val = 4'd0;
      endcase
    end else begin
      case (dig_idx)
        3'd0:    dig_val = cur_r.val[3:0];
        3'd1:    dig_val = cur_r.val[7:4];
        default: dig_val = 4'd0;
      endcase
    end
  end

  assign emit_item.out_char = (cur_r.pre_cnt != 2'd0) ? cur_r.pre0 : digit_char(dig_val);
  assign emit_item.run_end  = cur_r.run_end && cur_last;

  // Current job: load the next one, or consume one character.
  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    if (q_pop) begin
      cur_nxt       = head;
      cur_valid_nxt = 1'b1;
    end else if (finish) begin
      cur_valid_nxt = 1'b0;
    end else if (emit) begin
      if (cur_r.pre_cnt != 2'd0) begin
        cur_nxt.pre_cnt = cur_r.pre_cnt - 2'd1;
        cur_nxt.pre0    = cur_r.pre1;
      end else begin
        cur_nxt.ndig = cur_r.ndig - NDIG_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // Result queue.
  assign out_empty = (oq_cnt_r == 2'd0);
  assign out_data  = oq_r[oq_rd_r];
  assign deq       = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (emit) begin
        oq_wr_r <= !oq_wr_r;
      end
      if (deq) begin
        oq_rd_r <= !oq_rd_r;
      end
      oq_cnt_r <= oq_cnt_r + {1'b0, emit} - {1'b0, deq};
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      oq_r[oq_wr_r] <= emit_item;
    end
  end

endmodule

// ----- rtl/char_escape_encoder.sv -----
// ----------------------------------------------------------------------------
// Character escape encoder
// Turns a raw byte stream into escaped text, one character per result beat,
// using the following byte as lookahead for dropping leading zero digits.
// ----------------------------------------------------------------------------
// Throughput: one input beat per cycle while the job queue has two free
// entries; the back end writes one character per cycle while its result
// queue has room, and a beat produces 0 to 20 characters.
// Path: when the back end is idle, the first character of a job reaches the
// result ports through the job queue, the current job and the result queue.
// Reset (rst_n low, synchronous): queues empty, no byte pending, mode hex.
module char_escape_encoder #(
  parameter int JOB_DEPTH = cee_pkg::JOB_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  cee_pkg::in_item_t   in_data,
  output logic                in_full,
  output logic                out_empty,
  input  logic                out_pop,
  output cee_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_data,
  output logic                cfg_ready
);
  import cee_pkg::*;

  job_push_t push;
  job_t      head;
  logic      q_empty;
  logic      q_full;
  logic      q_pop;

  // Front end: configuration, pending byte, classification.
  cee_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .q_full    (q_full),
    .in_full   (in_full),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .push      (push)
  );

  // Job queue between the two halves.
  cee_job_queue #(
    .DEPTH (JOB_DEPTH)
  ) u_job_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (q_pop),
    .head  (head),
    .empty (q_empty),
    .full  (q_full)
  );

  // Back end: character sequencer and result queue.
  cee_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
